FILE: hdl/b2v_pkg.sv
// ----------------------------------------------------------------------------
// b2v_pkg
// Shared constants, codes and control types for the buffer-to-view converter.
// ----------------------------------------------------------------------------
`default_nettype none

package b2v_pkg;

  localparam int MAX_DIMS = 8;
  localparam int DIM_W    = $clog2(MAX_DIMS);
  localparam int CNT_W    = $clog2(MAX_DIMS + 1);
  localparam int IDX_W    = 32;
  localparam int VIEW_W   = IDX_W - 1;
  localparam int EXT_W    = 16;
  localparam int ADDR_W   = 4;

  localparam logic [VIEW_W-1:0] COUNT_LIMIT = {VIEW_W{1'b1}};

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_CONVERT = 1'b1;

  localparam logic [1:0] MODE_ERROR = 2'd0;
  localparam logic [1:0] MODE_CLAMP = 2'd1;
  localparam logic [1:0] MODE_WRAP  = 2'd2;

  localparam logic [1:0] REG_NUM_DIMS    = 2'd0;
  localparam logic [1:0] REG_MAJOR_ORDER = 2'd1;
  localparam logic [1:0] REG_INDEX_MODE  = 2'd2;

  typedef struct packed {
    logic load_wr;
    logic conv_start;
    logic cnt_step;
    logic check;
    logic div_start;
    logic div_wrap;
    logic wrap_fix;
    logic dim_skip;
    logic dim_take;
    logic dim_acc;
    logic out_load;
  } b2v_cmd_t;

  typedef struct packed {
    logic dims_done;
    logic fail;
    logic wrap;
    logic stride_zero;
    logic div_done;
  } b2v_sts_t;

endpackage

`default_nettype wire

FILE: hdl/b2v_div.sv
// ----------------------------------------------------------------------------
// b2v_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module b2v_div
  import b2v_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [IDX_W-1:0] dividend,
  input  wire logic [IDX_W-1:0] divisor,
  output logic                  done,
  output logic [IDX_W-1:0]      quot,
  output logic [IDX_W-1:0]      rem
);

  localparam int STEP_W = $clog2(IDX_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [IDX_W-1:0]  dvs;
  logic [IDX_W:0]    trial;
  logic              fits;

  assign trial = {rem, quot[IDX_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem  <= IDX_W'(trial - {1'b0, dvs});
        quot <= {quot[IDX_W-2:0], 1'b1};
      end else begin
        rem  <= trial[IDX_W-1:0];
        quot <= {quot[IDX_W-2:0], 1'b0};
      end
      step <= step + 1'b1;
      if (step == STEP_W'(IDX_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/b2v_dpath.sv
// ----------------------------------------------------------------------------
// b2v_dpath
// Dimension tables, element count, index check and digit accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module b2v_dpath
  import b2v_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire b2v_cmd_t          cmd,
  output b2v_sts_t               sts,
  input  wire logic [3:0]        num_dims,
  input  wire logic              major_order,
  input  wire logic [1:0]        index_mode,
  input  wire logic [DIM_W-1:0]  dim_select,
  input  wire logic [EXT_W-1:0]  extent,
  input  wire logic [IDX_W-1:0]  stride,
  input  wire logic [IDX_W-1:0]  buffer_index,
  output logic [VIEW_W-1:0]      view_index,
  output logic                   status
);

  logic [EXT_W-1:0]  ext_mem [MAX_DIMS];
  logic [IDX_W-1:0]  str_mem [MAX_DIMS];

  logic [IDX_W-1:0]  bidx;
  logic [VIEW_W-1:0] count;
  logic [CNT_W-1:0]  dcnt;
  logic [VIEW_W-1:0] idx;
  logic [VIEW_W-1:0] sum;
  logic [VIEW_W-1:0] k;
  logic [VIEW_W-1:0] mag;
  logic              err;

  logic [CNT_W-1:0]         dims;
  logic [CNT_W-1:0]         pos;
  logic [DIM_W-1:0]         raddr;
  logic [EXT_W-1:0]         ext;
  logic [IDX_W-1:0]         s;
  logic [IDX_W-1:0]         sabs;
  logic [IDX_W-1:0]         babs;
  logic [VIEW_W+EXT_W-1:0]  prod_cnt;
  logic [VIEW_W-1:0]        count_sat;
  logic                     oor;
  logic                     len_zero;
  logic                     clamp;
  logic                     wrap;
  logic [IDX_W-1:0]         dvd;
  logic [IDX_W-1:0]         dvs;
  logic                     div_done;
  logic [IDX_W-1:0]         div_quot;
  logic [IDX_W-1:0]         div_rem;
  logic [VIEW_W-1:0]        r;
  logic [IDX_W-1:0]         kfull;
  logic [2*VIEW_W-1:0]      prod_dim;

  assign dims  = (num_dims > CNT_W'(MAX_DIMS)) ? CNT_W'(MAX_DIMS) : CNT_W'(num_dims);
  assign pos   = major_order ? CNT_W'(dims - dcnt - 1'b1) : dcnt;
  assign raddr = cmd.cnt_step ? dcnt[DIM_W-1:0] : pos[DIM_W-1:0];
  assign ext   = ext_mem[raddr];
  assign s     = str_mem[raddr];
  assign sabs  = s[IDX_W-1] ? IDX_W'(-s) : s;
  assign babs  = bidx[IDX_W-1] ? IDX_W'(-bidx) : bidx;

  assign prod_cnt  = count * ext;
  assign count_sat = (prod_cnt[VIEW_W+EXT_W-1:VIEW_W] != '0) ? COUNT_LIMIT
                                                              : prod_cnt[VIEW_W-1:0];

  assign len_zero = count == '0;
  assign oor      = bidx[IDX_W-1] || (bidx[VIEW_W-1:0] >= count);
  assign clamp    = index_mode == MODE_CLAMP;
  assign wrap     = index_mode == MODE_WRAP;

  assign dvd = cmd.div_wrap ? babs : {1'b0, idx};
  assign dvs = cmd.div_wrap ? {1'b0, count} : sabs;

  assign r        = div_rem[VIEW_W-1:0];
  assign kfull    = s[IDX_W-1] ? IDX_W'({{(IDX_W-EXT_W){1'b0}}, ext} - 1'b1 - div_quot)
                               : div_quot;
  assign prod_dim = k * mag;

  b2v_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    sts.dims_done   = dcnt == dims;
    sts.fail        = len_zero || (!clamp && !wrap && oor);
    sts.wrap        = wrap;
    sts.stride_zero = s == '0;
    sts.div_done    = div_done;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      ext_mem[dim_select] <= extent;
      str_mem[dim_select] <= stride;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.conv_start) begin
      bidx  <= buffer_index;
      count <= VIEW_W'(1);
      dcnt  <= '0;
    end
    if (cmd.cnt_step) begin
      count <= count_sat;
      dcnt  <= dcnt + 1'b1;
    end
    if (cmd.check) begin
      err  <= sts.fail;
      dcnt <= '0;
      sum  <= '0;
      if (clamp && bidx[IDX_W-1]) begin
        idx <= '0;
      end else if (clamp && oor) begin
        idx <= count - 1'b1;
      end else begin
        idx <= bidx[VIEW_W-1:0];
      end
    end
    if (cmd.wrap_fix) begin
      idx <= (bidx[IDX_W-1] && r != '0) ? count - r : r;
    end
    if (cmd.dim_skip) begin
      dcnt <= dcnt + 1'b1;
    end
    if (cmd.dim_take) begin
      idx <= r;
      k   <= kfull[VIEW_W-1:0];
      mag <= sabs[VIEW_W-1:0];
    end
    if (cmd.dim_acc) begin
      sum  <= sum + prod_dim[VIEW_W-1:0];
      dcnt <= dcnt + 1'b1;
    end
    if (cmd.out_load) begin
      view_index <= err ? '0 : sum;
      status     <= err;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/b2v_ctrl.sv
// ----------------------------------------------------------------------------
// b2v_ctrl
// Sequencer for load and convert transactions and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module b2v_ctrl
  import b2v_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     action,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output b2v_cmd_t      cmd,
  input  wire b2v_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE, S_COUNT, S_CHECK, S_WRAP, S_DIM, S_DDIV, S_ACC, S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = state == S_IDLE;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.load_wr    = in_valid && action == ACT_LOAD;
        cmd.conv_start = in_valid && action == ACT_CONVERT;
      end
      S_COUNT: cmd.cnt_step = !sts.dims_done;
      S_CHECK: begin
        cmd.check     = 1'b1;
        cmd.div_start = !sts.fail && sts.wrap;
        cmd.div_wrap  = 1'b1;
      end
      S_WRAP: cmd.wrap_fix = sts.div_done;
      S_DIM: begin
        cmd.dim_skip  = !sts.dims_done && sts.stride_zero;
        cmd.div_start = !sts.dims_done && !sts.stride_zero;
      end
      S_DDIV: cmd.dim_take = sts.div_done;
      S_ACC: cmd.dim_acc = 1'b1;
      S_DONE: cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (cmd.conv_start) begin
          state <= S_COUNT;
        end
        S_COUNT: if (sts.dims_done) begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (sts.fail) begin
            state <= S_DONE;
          end else if (sts.wrap) begin
            state <= S_WRAP;
          end else begin
            state <= S_DIM;
          end
        end
        S_WRAP: if (sts.div_done) begin
          state <= S_DIM;
        end
        S_DIM: begin
          if (sts.dims_done) begin
            state <= S_DONE;
          end else if (!sts.stride_zero) begin
            state <= S_DDIV;
          end
        end
        S_DDIV: if (sts.div_done) begin
          state <= S_ACC;
        end
        S_ACC: state <= S_DIM;
        S_DONE: if (out_free) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/buffer_to_view_index.sv
// ----------------------------------------------------------------------------
// buffer_to_view_index
// Converts a signed buffer index of a strided array into its dense view index.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one transaction per item. A load
// transaction (action 0) writes extent and stride of dim_select in the cycle
// it is taken and produces no result. A convert transaction (action 1)
// produces one result on the output channel (out_valid/out_ready).
// Convert steps from acceptance to out_valid: a count step per dimension in
// use, the index check, a division in wrap mode, then per dimension a division
// and accumulate step for a non-zero stride or a skip for a zero stride.
// One transaction is processed at a time; in_ready is high only when idle.
// The result sits in an output register, so a new transaction is taken while
// it waits; a finished convert holds until that register is free.
// Reset (rst, synchronous) clears the handshake state and sets num_dims to 1,
// major_order and index_mode to 0. Tables are undefined until loaded.
// Registers via APB at 0x0 num_dims, 0x4 major_order, 0x8 index_mode.
// ----------------------------------------------------------------------------
`default_nettype none

module buffer_to_view_index
  import b2v_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [ADDR_W-1:0]        paddr,
  input  wire logic [31:0]              pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     action,
  input  wire logic [DIM_W-1:0]         dim_select,
  input  wire logic [EXT_W-1:0]         extent,
  input  wire logic signed [IDX_W-1:0]  stride,
  input  wire logic signed [IDX_W-1:0]  buffer_index,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [VIEW_W-1:0]             view_index,
  output logic                          status
);

  logic [3:0] num_dims;
  logic       major_order;
  logic [1:0] index_mode;
  b2v_cmd_t   cmd;
  b2v_sts_t   sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims    <= 4'd1;
      major_order <= 1'b0;
      index_mode  <= MODE_ERROR;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_NUM_DIMS:    num_dims    <= pwdata[3:0];
        REG_MAJOR_ORDER: major_order <= pwdata[0];
        REG_INDEX_MODE:  index_mode  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_NUM_DIMS:    prdata = {28'd0, num_dims};
      REG_MAJOR_ORDER: prdata = {31'd0, major_order};
      REG_INDEX_MODE:  prdata = {30'd0, index_mode};
      default:         prdata = '0;
    endcase
  end

  b2v_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .action    (action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  b2v_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .num_dims     (num_dims),
    .major_order  (major_order),
    .index_mode   (index_mode),
    .dim_select   (dim_select),
    .extent       (extent),
    .stride       (stride),
    .buffer_index (buffer_index),
    .view_index   (view_index),
    .status       (status)
  );

endmodule

`default_nettype wire

FILE: hdl/b2v_checker.sv
// ----------------------------------------------------------------------------
// b2v_checker
// Port-level checks on the result channel and on pready, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module b2v_checker
  import b2v_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              pready,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              action,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [VIEW_W-1:0] view_index,
  input wire logic              status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(view_index) && $stable(status))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> view_index == '0)
    else $error("failed transaction with non-zero view index");

  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action == ACT_LOAD && !out_valid |=> !out_valid)
    else $error("load transaction produced a result");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && pready)
    else $error("result valid after reset");

endmodule

bind buffer_to_view_index b2v_checker u_b2v_checker (
  .clk        (clk),
  .rst        (rst),
  .pready     (pready),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .action     (action),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .view_index (view_index),
  .status     (status)
);

`default_nettype wire
